>>> hw/rtl/hff_pkg.sv
// shared types, constants and helpers of the hex float formatter
`default_nettype none

package hff_pkg;

  localparam int unsigned FracBits    = 52;
  localparam int unsigned FracNibbles = 13;
  localparam int unsigned BiasedBits  = 11;
  localparam int unsigned ExpBits     = 12;
  localparam int unsigned ExpMagBits  = 11;
  localparam int unsigned BcdBits     = 16;
  localparam int unsigned ExpBias     = 1023;
  localparam int unsigned SubnormMag  = 1022;

  localparam logic [6:0] AsciiZero  = 7'h30;
  localparam logic [6:0] AsciiDot   = 7'h2E;
  localparam logic [6:0] AsciiPlus  = 7'h2B;
  localparam logic [6:0] AsciiMinus = 7'h2D;
  localparam logic [6:0] AsciiLowX  = 7'h78;
  localparam logic [6:0] AsciiUpX   = 7'h58;
  localparam logic [6:0] AsciiLowP  = 7'h70;
  localparam logic [6:0] AsciiUpP   = 7'h50;
  localparam logic [6:0] AsciiLowA  = 7'h61;
  localparam logic [6:0] AsciiUpA   = 7'h41;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRound = 4'b0010,
    StConv  = 4'b0100,
    StEmit  = 4'b1000
  } hff_state_e;

  typedef struct packed {
    logic load;
    logic round;
    logic conv;
    logic emit;
  } hff_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic out_free;
    logic last;
  } hff_status_t;

  function automatic logic [6:0] hex_char(input logic [3:0] v, input logic up);
    logic [6:0] base;
    base = up ? AsciiUpA : AsciiLowA;
    if (v < 4'd10) begin
      return AsciiZero + {3'b000, v};
    end
    return base + {3'b000, v} - 7'd10;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hff_ctrl.sv
// controller state machine of the hex float formatter
`default_nettype none

module hff_ctrl import hff_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire hff_status_t status_i,
  output hff_cmd_t    cmd_o
);

  hff_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRound;
        end
      end
      StRound: begin
        cmd_o.round = 1'b1;
        state_d     = StConv;
      end
      StConv: begin
        cmd_o.conv = 1'b1;
        if (status_i.conv_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hff_datapath.sv
// datapath: decode, rounding, exponent to bcd and character output register
`default_nettype none

module hff_datapath import hff_pkg::*; #(
  parameter int unsigned MaxDigits = 50
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [63:0] double_bits_i,
  input  wire         exact_mode_i,
  input  wire  [5:0]  digit_count_i,
  input  wire         upper_case_i,
  input  wire hff_cmd_t cmd_i,
  output hff_status_t status_o,
  input  wire         out_stall_i,
  output logic        out_valid_o,
  output logic [6:0]  out_char_o,
  output logic        last_char_o
);

  logic [FracBits-1:0]   frac_q;
  logic                  lead_q;
  logic [ExpBits-1:0]    exp_q;
  logic [5:0]            ndig_q;
  logic                  round_en_q;
  logic                  upper_q;
  logic [ExpMagBits-1:0] bin_q;
  logic [BcdBits-1:0]    bcd_q;
  logic [3:0]            cnt_q;
  logic [5:0]            pos_q;
  logic                  out_valid_q;
  logic [6:0]            out_char_q;
  logic                  last_q;

  // decode of the incoming beat
  logic [BiasedBits-1:0] biased;
  logic [FracBits-1:0]   frac_in;
  logic [ExpBits-1:0]    exp_in;
  logic [3:0]            exact_n;

  assign biased  = double_bits_i[62:52];
  assign frac_in = double_bits_i[FracBits-1:0];

  always_comb begin
    exact_n = 4'd0;
    for (int k = FracNibbles - 1; k >= 0; k--) begin
      if (frac_in[4*k +: 4] != 4'd0) begin
        exact_n = 4'(FracNibbles - k);
      end
    end
  end

  always_comb begin
    if (biased == '0) begin
      exp_in = (frac_in == '0) ? '0 : (ExpBits'(0) - ExpBits'(SubnormMag));
    end else begin
      exp_in = {1'b0, biased} - ExpBits'(ExpBias);
    end
  end

  // round to nearest even at the cut
  logic [5:0]          shift;
  logic [FracBits:0]   one_w;
  logic [FracBits-1:0] unit, half, mask, rem, kept;
  logic [FracBits:0]   sum;
  logic                last_kept, round_up;
  logic [FracBits-1:0] frac_r;
  logic                lead_r;
  logic [ExpBits-1:0]  exp_r, mag_w;

  assign shift     = 6'((FracNibbles - 32'(ndig_q)) * 4);
  assign one_w     = (FracBits+1)'(1) << shift;
  assign unit      = one_w[FracBits-1:0];
  assign half      = one_w[FracBits:1];
  assign mask      = unit - FracBits'(1);
  assign rem       = frac_q & mask;
  assign kept      = frac_q & ~mask;
  assign sum       = {1'b0, kept} + one_w;
  assign last_kept = (ndig_q != 6'd0) ? |(frac_q & unit) : lead_q;
  assign round_up  = (rem > half) || ((rem == half) && last_kept);

  always_comb begin
    frac_r = frac_q;
    lead_r = lead_q;
    exp_r  = exp_q;
    if (round_en_q) begin
      frac_r = kept;
      if (round_up) begin
        if (sum[FracBits]) begin
          frac_r = '0;
          if (lead_q) begin
            exp_r = exp_q + ExpBits'(1);
          end else begin
            lead_r = 1'b1;
          end
        end else begin
          frac_r = sum[FracBits-1:0];
        end
      end
    end
  end

  assign mag_w = exp_r[ExpBits-1] ? (ExpBits'(0) - exp_r) : exp_r;

  // double dabble step
  logic [BcdBits-1:0] bcd_adj;

  always_comb begin
    for (int d = 0; d < BcdBits / 4; d++) begin
      bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
                                                    : bcd_q[4*d +: 4];
    end
  end

  // character selection
  logic [5:0] dig_n, p_pos, last_pos, k_off;
  logic       has_dot;
  logic [1:0] ne_m1, idx;
  logic [6:0] char_w;
  logic       is_digit;

  assign dig_n    = (ndig_q > 6'(MaxDigits)) ? 6'(MaxDigits) : ndig_q;
  assign has_dot  = (dig_n != 6'd0);
  assign p_pos    = has_dot ? dig_n + 6'd4 : 6'd3;
  assign last_pos = p_pos + 6'd2 + {4'b0000, ne_m1};
  assign k_off    = pos_q - p_pos - 6'd2;
  assign idx      = ne_m1 - k_off[1:0];

  always_comb begin
    priority if (bcd_q[15:12] != 4'd0) begin
      ne_m1 = 2'd3;
    end else if (bcd_q[11:8] != 4'd0) begin
      ne_m1 = 2'd2;
    end else if (bcd_q[7:4] != 4'd0) begin
      ne_m1 = 2'd1;
    end else begin
      ne_m1 = 2'd0;
    end
  end

  always_comb begin
    is_digit = 1'b0;
    priority if (pos_q == 6'd0) begin
      char_w = AsciiZero;
    end else if (pos_q == 6'd1) begin
      char_w = upper_q ? AsciiUpX : AsciiLowX;
    end else if (pos_q == 6'd2) begin
      char_w = AsciiZero + {6'd0, lead_q};
    end else if (has_dot && pos_q == 6'd3) begin
      char_w = AsciiDot;
    end else if (pos_q < p_pos) begin
      char_w   = hex_char(frac_q[FracBits-1 -: 4], upper_q);
      is_digit = 1'b1;
    end else if (pos_q == p_pos) begin
      char_w = upper_q ? AsciiUpP : AsciiLowP;
    end else if (pos_q == p_pos + 6'd1) begin
      char_w = exp_q[ExpBits-1] ? AsciiMinus : AsciiPlus;
    end else begin
      char_w = AsciiZero + {3'b000, bcd_q[4*idx +: 4]};
    end
  end

  assign status_o.conv_done = (cnt_q == 4'(ExpMagBits - 1));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign status_o.last      = (pos_q == last_pos);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      frac_q     <= frac_in;
      lead_q     <= (biased != '0);
      exp_q      <= exp_in;
      ndig_q     <= exact_mode_i ? {2'b00, exact_n} : digit_count_i;
      round_en_q <= !exact_mode_i && (digit_count_i < 6'(FracNibbles));
      upper_q    <= upper_case_i;
      pos_q      <= '0;
      cnt_q      <= '0;
    end
    if (cmd_i.round) begin
      frac_q <= frac_r;
      lead_q <= lead_r;
      exp_q  <= exp_r;
      bin_q  <= mag_w[ExpMagBits-1:0];
      bcd_q  <= '0;
    end
    if (cmd_i.conv) begin
      bcd_q <= {bcd_adj[BcdBits-2:0], bin_q[ExpMagBits-1]};
      bin_q <= {bin_q[ExpMagBits-2:0], 1'b0};
      cnt_q <= cnt_q + 4'd1;
    end
    if (cmd_i.emit) begin
      pos_q      <= pos_q + 6'd1;
      out_char_q <= char_w;
      last_q     <= status_o.last;
      if (is_digit) begin
        frac_q <= {frac_q[FracBits-5:0], 4'h0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

>>> hw/rtl/hex_float_formatter.sv
// top level of the hex float formatter
// Formats the bit pattern of a double as hex-float text "0xH.HHHp+D", one
// ASCII character per output beat; last_char_o marks the final character.
// Input channel: in_valid_i / in_stall_o with double_bits_i, exact_mode_i,
// digit_count_i and upper_case_i. A beat is taken when valid is high and
// stall is low. Output channel: out_valid_o / out_stall_i with out_char_o
// and last_char_o, held in an output register.
// After an input beat the controller passes a rounding state and the binary
// to bcd conversion of the exponent before the first character is shown.
// Throughput: one character per cycle, stepped by the emit counter, while
// the output is not stalled; an item has at most 60 characters with the
// default MAX_DIGITS of 50. in_stall_o stays high from the input beat until
// the last character sits in the output register; the next item is then
// taken while that character still waits.
// A stall on the output freezes the output register and the emit counter.
// Reset clears the controller and the output valid; no clearing pass.
`default_nettype none

module hex_float_formatter import hff_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 50
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire [63:0] double_bits_i,
  input  wire        exact_mode_i,
  input  wire [5:0]  digit_count_i,
  input  wire        upper_case_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [6:0] out_char_o,
  output logic       last_char_o
);

  hff_cmd_t    cmd;
  hff_status_t status;

  hff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hff_datapath #(
    .MaxDigits (MAX_DIGITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .double_bits_i (double_bits_i),
    .exact_mode_i  (exact_mode_i),
    .digit_count_i (digit_count_i),
    .upper_case_i  (upper_case_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_char_o    (out_char_o),
    .last_char_o   (last_char_o)
  );

`ifndef SYNTH
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("no stall after input beat");

  a_idle_holds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_stall_o |-> last_char_o)
    else $error("idle with a non-final character pending");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o && last_char_o)
    else $error("finished without final character");
`endif

endmodule

`default_nettype wire
